### rtl/stse_pkg.sv
`default_nettype none

package stse_pkg;

    localparam int unsigned IDX_W   = 10;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned PROBE_W = 4;

    // Table size; the index, length and probe count widths above are sized for it
    localparam int unsigned TABLE_DEPTH = 1024;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic [IDX_W-1:0]         entry_index;
        logic signed [WORD_W-1:0] entry_value;
        logic signed [WORD_W-1:0] search_key;
    } query_t;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   match_index;
        logic [PROBE_W-1:0] probe_count;
        logic [LEN_W-1:0]   insert_position;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXACT,
        ST_LB_INIT,
        ST_LB,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic write;       // store the accepted entry
        logic start;       // capture key, open range [0, len)
        logic cmp_exact;   // compare read data, early-exit search
        logic lb_init;     // reopen range [0, len) for the lower bound
        logic cmp_lower;   // compare read data, lower-bound search
        logic lower_mode;  // midpoint rounding of the lower-bound search
        logic load_out;    // copy results into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic range_open;  // updated range still holds an entry
        logic hit;         // exact compare met an equal entry
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/stse_ctrl.sv
`default_nettype none

module stse_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                query_valid,
    input  wire logic                query_opcode,
    output logic                     query_stall,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output stse_pkg::dp_cmd_t        cmd,
    input  wire stse_pkg::dp_status_t status
);
    import stse_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   query_xfer;

    assign query_stall  = (state_reg != ST_IDLE);
    assign query_xfer   = query_valid && !query_stall;
    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_xfer)
                begin
                    if (query_opcode == OP_WRITE)
                    begin
                        cmd.write = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = status.range_open ? ST_EXACT : ST_LB_INIT;
                    end
                end
            end
            ST_EXACT:
            begin
                cmd.cmp_exact = 1'b1;
                if (status.hit || !status.range_open)
                begin
                    state_next = ST_LB_INIT;
                end
            end
            ST_LB_INIT:
            begin
                cmd.lb_init    = 1'b1;
                cmd.lower_mode = 1'b1;
                state_next     = status.range_open ? ST_LB : ST_DONE;
            end
            ST_LB:
            begin
                cmd.cmp_lower  = 1'b1;
                cmd.lower_mode = 1'b1;
                if (!status.range_open)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && result_stall;
        end
    end

endmodule

`default_nettype wire

### rtl/stse_dp.sv
`default_nettype none

module stse_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire stse_pkg::dp_cmd_t             cmd,
    output stse_pkg::dp_status_t               status,
    input  wire stse_pkg::query_t              query,
    input  wire logic                          cfg_we,
    input  wire logic [stse_pkg::LEN_W-1:0]    cfg_len,
    output stse_pkg::result_t                  result
);
    import stse_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic signed [WORD_W-1:0] table_mem [TABLE_DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;

    logic [LEN_W-1:0]         table_length_reg;
    logic signed [WORD_W-1:0] key_reg;
    logic [LEN_W-1:0]         lo_reg;
    logic [LEN_W-1:0]         hi_reg;
    logic [LEN_W-1:0]         mid_reg;
    logic [PROBE_W-1:0]       probes_reg;
    logic                     hit_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    result_t                  result_reg;

    logic [LEN_W-1:0]         len_sat;
    logic [LEN_W-1:0]         lo_next;
    logic [LEN_W-1:0]         hi_next;
    logic [LEN_W:0]           mid_sum;
    logic [LEN_W-1:0]         mid_next;
    logic [PROBE_W-1:0]       probes_next;
    logic                     hit_next;
    logic [IDX_W-1:0]         hit_idx_next;
    logic signed [WORD_W-1:0] key_next;
    logic                     equal;
    logic                     less;

    assign len_sat = (32'(table_length_reg) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH)
                                                           : table_length_reg;

    assign equal = (rd_data_reg == key_reg);
    assign less  = (rd_data_reg < key_reg);

    always_comb
    begin
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        probes_next  = probes_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        key_next     = key_reg;

        priority if (cmd.start)
        begin
            lo_next      = '0;
            hi_next      = len_sat;
            probes_next  = '0;
            hit_next     = 1'b0;
            hit_idx_next = '0;
            key_next     = query.search_key;
        end
        else if (cmd.cmp_exact)
        begin
            probes_next = probes_reg + PROBE_W'(1);
            priority if (equal)
            begin
                hit_next     = 1'b1;
                hit_idx_next = IDX_W'(mid_reg);
            end
            else if (less)
            begin
                lo_next = mid_reg + LEN_W'(1);
            end
            else
            begin
                hi_next = mid_reg;
            end
        end
        else if (cmd.lb_init)
        begin
            lo_next = '0;
            hi_next = len_sat;
        end
        else if (cmd.cmp_lower)
        begin
            if (less)
            begin
                lo_next = mid_reg + LEN_W'(1);
            end
            else
            begin
                hi_next = mid_reg;
            end
        end
        else
        begin
            lo_next = lo_reg;
        end
    end

    // Next probe address straight from the updated range
    always_comb
    begin
        mid_sum = {1'b0, lo_next} + {1'b0, hi_next};
        if (!cmd.lower_mode)
        begin
            mid_sum = mid_sum - (LEN_W+1)'(1);
        end
        mid_next = mid_sum[LEN_W:1];
    end

    assign status.range_open = (lo_next < hi_next);
    assign status.hit        = cmd.cmp_exact && equal;

    always_ff @(posedge clk)
    begin
        if (cmd.write && (32'(query.entry_index) < TABLE_DEPTH))
        begin
            table_mem[AW'(query.entry_index)] <= query.entry_value;
        end
        rd_data_reg <= table_mem[AW'(mid_next)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            table_length_reg <= cfg_len;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        probes_reg  <= probes_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        key_reg     <= key_next;
        if (cmd.load_out)
        begin
            result_reg.found           <= hit_reg;
            result_reg.match_index     <= hit_idx_reg;
            result_reg.probe_count     <= probes_reg;
            result_reg.insert_position <= lo_reg;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

### rtl/sorted_table_search_engine_unit.sv
// Sorted table search engine.
// Query channel (query_valid / query_stall / query): opcode 0 writes
// entry_value into table position entry_index and gives no result;
// opcode 1 searches for search_key over the first table_length entries
// and gives one result on the result channel.
// A search runs an early-exit midpoint search, then a lower-bound search, on
// one table read port with one probe per cycle. The result becomes valid in
// the same cycle that the block returns to idle and can take the next item.
// query_stall is high from the cycle after a search is accepted until its
// result is loaded; writes are taken every cycle while no search is in
// flight.
// Config channel (cfg_valid / cfg_ready / cfg_data) writes table_length;
// cfg_ready is always high, write only while no search is in flight.
// Reset clears table_length and the handshake state; table contents are
// undefined until written. A result held under result_stall stays in the
// output register; the next search finishes and waits behind it.
`default_nettype none

module sorted_table_search_engine_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       query_valid,
    output logic                            query_stall,
    input  wire stse_pkg::query_t           query,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output stse_pkg::result_t               result,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [stse_pkg::LEN_W-1:0] cfg_data
);
    import stse_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    stse_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_opcode (query.opcode),
        .query_stall  (query_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    stse_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .query   (query),
        .cfg_we  (cfg_valid && cfg_ready),
        .cfg_len (cfg_data),
        .result  (result)
    );

endmodule

`default_nettype wire

### tb/sv/search_result_checker.sv
`timescale 1ns / 100ps

module search_result_checker #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           query_valid,
    input  logic                           query_stall,
    input  stse_pkg::query_t               query,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  stse_pkg::result_t              result,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [stse_pkg::LEN_W-1:0]     cfg_data,
    output int                             mismatches,
    output int                             pending,
    output int                             results_checked
);

    import stse_pkg::*;

    logic signed [WORD_W-1:0] entry_mirror [TABLE_DEPTH];
    logic [LEN_W-1:0]         length_reg = '0;
    result_t                  expected_results [$];
    int                       error_total = 0;
    int                       checked_total = 0;

    initial begin
        mismatches      = 0;
        pending         = 0;
        results_checked = 0;
    end

    // Early-exit midpoint search, then lower bound, over the mirrored table.
    function automatic result_t predict_search(input logic signed [WORD_W-1:0] key);
        result_t     r;
        int unsigned span_len;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        r        = '0;
        span_len = (length_reg > TABLE_DEPTH) ? TABLE_DEPTH : length_reg;
        lo       = 0;
        hi       = span_len;
        while (lo < hi && !r.found) begin
            mid           = (lo + hi - 1) / 2;
            r.probe_count = r.probe_count + 1'b1;
            if (entry_mirror[mid] == key) begin
                r.found       = 1'b1;
                r.match_index = mid[IDX_W-1:0];
            end
            else if (entry_mirror[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        lo = 0;
        hi = span_len;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (entry_mirror[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        r.insert_position = lo[LEN_W-1:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_total++;
        end
    endtask

    always @(posedge clk) begin : monitor
        result_t due;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                length_reg = cfg_data;
            if (result_valid && !result_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                             $time, result.found, result.match_index, result.probe_count,
                             result.insert_position);
                    error_total++;
                end
                else begin
                    due = expected_results.pop_front();
                    compare_field("found", due.found, result.found);
                    compare_field("match_index", due.match_index, result.match_index);
                    compare_field("probe_count", due.probe_count, result.probe_count);
                    compare_field("insert_position", due.insert_position,
                                  result.insert_position);
                end
                checked_total++;
            end
            if (query_valid && !query_stall) begin
                if (query.opcode == OP_WRITE)
                    entry_mirror[query.entry_index] = query.entry_value;
                else
                    expected_results.push_back(predict_search(query.search_key));
            end
        end
        mismatches      <= error_total;
        pending         <= expected_results.size();
        results_checked <= checked_total;
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import stse_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int DEPTH          = 1024;
    localparam int ITEM_TARGET    = 1750;
    localparam int DRAIN_CYCLES   = 30;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    logic             clk;
    logic             rst_n;
    logic             query_valid;
    logic             query_stall;
    query_t           query;
    logic             result_valid;
    logic             result_stall;
    result_t          result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int results_checked;

    logic signed [WORD_W-1:0] loaded_values [DEPTH];
    int   writes_sent    = 0;
    int   searches_sent  = 0;
    int   length_changes = 0;
    int   stuck_cycles   = 0;
    logic no_idle        = 1'b0;
    logic hold_req       = 1'b0;
    logic hold_done      = 1'b0;

    sorted_table_search_engine_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .query        (query),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    search_result_checker #(.TABLE_DEPTH(DEPTH)) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .query_valid     (query_valid),
        .query_stall     (query_stall),
        .query           (query),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    initial begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Mostly short, now and then long.
    function automatic int idle_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    always @(posedge clk) begin
        if (!rst_n || (query_valid && !query_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
            $display("end of test: mismatches");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // Result receiver: random stall runs, plus one long hold-off on request.
    initial begin
        forever begin
            if (hold_req && !hold_done) begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (no_idle || $urandom_range(0, 2) != 0) begin
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else begin
                result_stall <= 1'b1;
                repeat (idle_len()) @(posedge clk);
            end
        end
    end

    task automatic send_item(input query_t item);
        int gap;
        gap = no_idle ? 0 : (($urandom_range(0, 1) == 0) ? 0 : idle_len());
        if (gap > 0) begin
            query_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        query_valid <= 1'b1;
        query       <= item;
        @(posedge clk);
        while (query_stall) @(posedge clk);
        if (item.opcode == OP_WRITE)
            writes_sent++;
        else
            searches_sent++;
    endtask

    task automatic load_entry(input int idx, input logic signed [WORD_W-1:0] value);
        query_t item;
        item.opcode      = OP_WRITE;
        item.entry_index = idx[IDX_W-1:0];
        item.entry_value = value;
        item.search_key  = $urandom;
        loaded_values[idx] = value;
        send_item(item);
    endtask

    task automatic search_for(input logic signed [WORD_W-1:0] key);
        query_t item;
        item.opcode      = OP_SEARCH;
        item.entry_index = $urandom_range(0, DEPTH - 1);
        item.entry_value = $urandom;
        item.search_key  = key;
        send_item(item);
    endtask

    // Write entries 0..count-1 ascending from lowest, clamped to highest.
    task automatic load_sorted_prefix(input int count, input longint lowest,
                                      input longint highest, input bit pin_top);
        longint v;
        longint step_max;
        longint draw;
        v        = lowest;
        step_max = (highest - lowest) / ((count > 0) ? count : 1);
        for (int i = 0; i < count; i++) begin
            if (v > highest || (pin_top && i == count - 1))
                v = highest;
            load_entry(i, v[WORD_W-1:0]);
            draw = $urandom;
            v += draw % (step_max + 1);
        end
    endtask

    // Drain all searches before touching the length register.
    task automatic set_length(input logic [LEN_W-1:0] len);
        query_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        length_changes++;
    endtask

    function automatic logic signed [WORD_W-1:0] pick_key(input int n);
        int at;
        if (n == 0)
            return $urandom;
        at = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return loaded_values[at];
            5, 6:          return loaded_values[at] + (($urandom_range(0, 1) != 0) ? 1 : -1);
            7:             return $urandom;
            8:             return ($urandom_range(0, 1) != 0) ? WORD_MIN : WORD_MAX;
            default:       return ($urandom_range(0, 1) != 0) ? loaded_values[0] - 1
                                                              : loaded_values[n - 1] + 1;
        endcase
    endfunction

    initial begin
        int     len;
        int     n;
        int     count;
        int     phase;
        longint top;
        longint bottom;
        longint spread;
        query_valid = 1'b0;
        query       = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        phase       = 0;
        wait (rst_n);
        @(posedge clk);

        // Empty table straight out of reset.
        search_for(WORD_MIN);
        search_for(WORD_MAX);
        search_for(0);

        // Fill the whole table so that any length is legal from here on.
        load_sorted_prefix(DEPTH, WORD_MIN, WORD_MAX, 1'b1);

        set_length(DEPTH);
        search_for(loaded_values[0]);
        search_for(loaded_values[DEPTH - 1]);
        search_for(loaded_values[511]);
        search_for(loaded_values[300] + 1);
        search_for(0);
        search_for(WORD_MAX - 1);

        // Length above depth saturates.
        set_length('1);
        search_for(WORD_MAX);
        search_for(loaded_values[700]);
        search_for(WORD_MIN + 1);

        set_length(1);
        search_for(WORD_MIN);
        search_for(WORD_MAX);

        while (writes_sent + searches_sent < ITEM_TARGET) begin
            phase++;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(0, 40);
                6:                len = $urandom_range(41, DEPTH);
                7, 8: begin
                    case ($urandom_range(0, 4))
                        0:       len = 0;
                        1:       len = 1;
                        2:       len = DEPTH - 1;
                        3:       len = DEPTH;
                        default: len = 2047;
                    endcase
                end
                default:          len = $urandom_range(DEPTH + 1, 2047);
            endcase
            n = (len > DEPTH) ? DEPTH : len;
            no_idle <= (phase % 4 == 3);
            set_length(len[LEN_W-1:0]);

            // Rewrite a short prefix, kept no larger than the entry after it.
            if (n > 0 && n <= 40) begin
                top    = (n < DEPTH) ? longint'(loaded_values[n]) : longint'(WORD_MAX);
                spread = ($urandom_range(0, 1) != 0) ? n * $urandom_range(1, 3) : $urandom;
                bottom = top - spread;
                if (bottom < longint'(WORD_MIN))
                    bottom = WORD_MIN;
                load_sorted_prefix(n, bottom, top, 1'b0);
            end

            // Back up the block: long receiver hold-off, searches offered back to back.
            if (phase == 6) begin
                no_idle  <= 1'b1;
                hold_req <= 1'b1;
            end

            count = $urandom_range(4, 24);
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(0, 19) == 0)
                    load_entry($urandom_range(0, DEPTH - 1), $urandom);
                search_for(pick_key(n));
            end
        end

        query_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d table writes and %0d searches over %0d length settings,",
                 writes_sent, searches_sent, length_changes);
        $display("%0d results compared, including a %0d-cycle receiver hold-off.",
                 results_checked, HOLD_CYCLES);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
